// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion macros for the calendar conversion block, empty when SYNTH is set
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AST_IMPLY(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("same-cycle check failed");
`define AST_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("next-cycle check failed");
`else
`define AST_IMPLY(lbl, pre, post)
`define AST_NEXT(lbl, pre, post)
`endif
`endif

// ===== rtl/es2cal_pkg.sv =====
// ---------------------------------------------------------------------------
// es2cal_pkg
// shared types, command codes and constant tables of the calendar converter
// ---------------------------------------------------------------------------
package es2cal_pkg;

  localparam int unsigned IN_W   = 39;
  localparam int unsigned DAY_W  = 22;
  localparam int unsigned DATA_W = 52;

  localparam logic signed [IN_W-1:0] EPOCH_LOW  = -39'sd62135596800;
  localparam logic signed [IN_W-1:0] EPOCH_HIGH = 39'sd253402300799;

  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_LOAD = 4'd1;
  localparam logic [3:0] OP_DAY  = 4'd2;
  localparam logic [3:0] OP_HOUR = 4'd3;
  localparam logic [3:0] OP_MIN  = 4'd4;
  localparam logic [3:0] OP_LDAY = 4'd5;
  localparam logic [3:0] OP_Y400 = 4'd6;
  localparam logic [3:0] OP_Y100 = 4'd7;
  localparam logic [3:0] OP_Y4   = 4'd8;
  localparam logic [3:0] OP_Y1   = 4'd9;
  localparam logic [3:0] OP_YD   = 4'd10;
  localparam logic [3:0] OP_MON  = 4'd11;

  typedef struct packed {
    logic [3:0] op;
    logic [4:0] k;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic in_oor;
    logic mon_done;
  } sts_t;

  function automatic logic [IN_W-1:0] step_divisor(input logic [3:0] op,
                                                    input logic [4:0] k);
    logic [IN_W-1:0] base;
    base = '0;
    unique case (op)
      OP_DAY:  base = 39'd86400;
      OP_HOUR: base = 39'd3600;
      OP_MIN:  base = 39'd60;
      OP_Y400: base = 39'd146097;
      OP_Y100: base = 39'd36524;
      OP_Y4:   base = 39'd1461;
      OP_Y1:   base = 39'd365;
      default: base = '0;
    endcase
    return base << k;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    len = 5'd31;
    unique case (mon)
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd3:    len = 5'd30;
      4'd5:    len = 5'd30;
      4'd8:    len = 5'd30;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/es2cal_dp.sv =====
// ---------------------------------------------------------------------------
// es2cal_dp
// datapath: one shared compare and subtract unit, quotient and result registers
// ---------------------------------------------------------------------------
module es2cal_dp (
  input  logic                                  clk,
  input  es2cal_pkg::cmd_t                      cmd,
  input  logic [es2cal_pkg::IN_W-1:0]           in_data,
  output es2cal_pkg::sts_t                      sts,
  output logic [es2cal_pkg::DATA_W-1:0]         out_data,
  output logic                                  out_oor
);
  import es2cal_pkg::*;

  logic signed [IN_W-1:0] t_in;
  logic [IN_W-1:0]        s_in;
  logic [IN_W-1:0]        dv;
  logic                   take;
  logic                   leap;
  logic [4:0]             mlen;
  logic [IN_W-1:0]        rem_r, rem_nxt;
  logic [DAY_W-1:0]       day_r, day_nxt;
  logic [4:0]             hour_r, hour_nxt;
  logic [5:0]             min_r, min_nxt;
  logic [5:0]             sec_r, sec_nxt;
  logic [4:0]             q1_r, q1_nxt;
  logic [1:0]             q2_r, q2_nxt;
  logic [4:0]             q3_r, q3_nxt;
  logic [1:0]             q4_r, q4_nxt;
  logic [8:0]             yd_r, yd_nxt;
  logic [3:0]             mon_r, mon_nxt;
  logic [2:0]             wd_r, wd_nxt;
  logic [3:0]             wd_dbl;
  logic                   oor_r, oor_nxt;
  logic [13:0]            year_v;
  logic [2:0]             wday_v;
  logic [DATA_W-1:0]      data_r, data_nxt;
  logic                   out_oor_r, out_oor_nxt;

  assign t_in = in_data;
  assign s_in = t_in - EPOCH_LOW;
  assign sts.in_oor = (t_in < EPOCH_LOW) || (t_in > EPOCH_HIGH);

  assign dv   = step_divisor(cmd.op, cmd.k);
  assign take = rem_r >= dv;
  assign leap = (q4_r == 2'd3) && ((q3_r != 5'd24) || (q2_r == 2'd3));
  assign mlen = month_len(mon_r, leap);
  assign sts.mon_done = (rem_r < {34'd0, mlen}) || (mon_r == 4'd11);
  assign wd_dbl = {wd_r, take};

  assign year_v = 14'd1 + 14'(q1_r) * 14'd400 + 14'(q2_r) * 14'd100
                + {7'd0, q3_r, 2'd0} + {12'd0, q4_r};
  assign wday_v = (wd_r == 3'd6) ? 3'd0 : wd_r + 3'd1;

  always_comb begin
    rem_nxt  = rem_r;
    day_nxt  = day_r;
    hour_nxt = hour_r;
    min_nxt  = min_r;
    sec_nxt  = sec_r;
    q1_nxt   = q1_r;
    q2_nxt   = q2_r;
    q3_nxt   = q3_r;
    q4_nxt   = q4_r;
    yd_nxt   = yd_r;
    mon_nxt  = mon_r;
    wd_nxt   = wd_r;
    oor_nxt  = oor_r;
    if ((cmd.op == OP_DAY || cmd.op == OP_HOUR || cmd.op == OP_MIN || cmd.op == OP_Y400 ||
         cmd.op == OP_Y100 || cmd.op == OP_Y4 || cmd.op == OP_Y1) && take) begin
      rem_nxt = rem_r - dv;
    end
    unique case (cmd.op)
      OP_LOAD: begin
        rem_nxt = s_in;
        oor_nxt = sts.in_oor;
        wd_nxt  = 3'd0;
        mon_nxt = 4'd0;
      end
      OP_DAY: begin
        day_nxt = {day_r[DAY_W-2:0], take};
        wd_nxt  = (wd_dbl >= 4'd7) ? 3'(wd_dbl - 4'd7) : wd_dbl[2:0];
      end
      OP_HOUR: hour_nxt = {hour_r[3:0], take};
      OP_MIN:  min_nxt  = {min_r[4:0], take};
      OP_LDAY: begin
        sec_nxt = rem_r[5:0];
        rem_nxt = {17'd0, day_r};
      end
      OP_Y400: q1_nxt = {q1_r[3:0], take};
      OP_Y100: q2_nxt = {q2_r[0], take};
      OP_Y4:   q3_nxt = {q3_r[3:0], take};
      OP_Y1:   q4_nxt = {q4_r[0], take};
      OP_YD:   yd_nxt = rem_r[8:0];
      OP_MON: begin
        if (!sts.mon_done) begin
          rem_nxt = rem_r - {34'd0, mlen};
          mon_nxt = mon_r + 4'd1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    data_nxt    = data_r;
    out_oor_nxt = out_oor_r;
    if (cmd.load_out) begin
      out_oor_nxt = oor_r;
      if (oor_r) begin
        data_nxt = '0;
      end else begin
        data_nxt = {sec_r, min_r, hour_r, wday_v, yd_r, rem_r[4:0], mon_r, year_v};
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    day_r     <= day_nxt;
    hour_r    <= hour_nxt;
    min_r     <= min_nxt;
    sec_r     <= sec_nxt;
    q1_r      <= q1_nxt;
    q2_r      <= q2_nxt;
    q3_r      <= q3_nxt;
    q4_r      <= q4_nxt;
    yd_r      <= yd_nxt;
    mon_r     <= mon_nxt;
    wd_r      <= wd_nxt;
    oor_r     <= oor_nxt;
    data_r    <= data_nxt;
    out_oor_r <= out_oor_nxt;
  end

  assign out_data = data_r;
  assign out_oor  = out_oor_r;

endmodule

// ===== rtl/es2cal_ctrl.sv =====
// ---------------------------------------------------------------------------
// es2cal_ctrl
// sequencer: steps the shared divide unit through its phases, owns handshakes
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module es2cal_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  es2cal_pkg::sts_t  sts,
  output es2cal_pkg::cmd_t  cmd
);
  import es2cal_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DAY  = 4'd1;
  localparam logic [3:0] S_HOUR = 4'd2;
  localparam logic [3:0] S_MIN  = 4'd3;
  localparam logic [3:0] S_LDAY = 4'd4;
  localparam logic [3:0] S_Y400 = 4'd5;
  localparam logic [3:0] S_Y100 = 4'd6;
  localparam logic [3:0] S_Y4   = 4'd7;
  localparam logic [3:0] S_Y1   = 4'd8;
  localparam logic [3:0] S_YD   = 4'd9;
  localparam logic [3:0] S_MON  = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic [4:0] k_r, k_nxt;
  logic       out_vld_r, out_vld_nxt;
  logic       last_k;
  logic       out_free;

  assign last_k   = (k_r == 5'd0);
  assign out_free = !out_vld_r || out_tready;

  always_comb begin
    state_nxt    = state_r;
    k_nxt        = (k_r == 5'd0) ? 5'd0 : k_r - 5'd1;
    cmd.op       = OP_NONE;
    cmd.k        = k_r;
    cmd.load_out = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          state_nxt = sts.in_oor ? S_FIN : S_DAY;
          k_nxt     = 5'(DAY_W - 1);
        end
      end
      S_DAY: begin
        cmd.op = OP_DAY;
        if (last_k) begin
          state_nxt = S_HOUR;
          k_nxt     = 5'd4;
        end
      end
      S_HOUR: begin
        cmd.op = OP_HOUR;
        if (last_k) begin
          state_nxt = S_MIN;
          k_nxt     = 5'd5;
        end
      end
      S_MIN: begin
        cmd.op = OP_MIN;
        if (last_k) begin
          state_nxt = S_LDAY;
        end
      end
      S_LDAY: begin
        cmd.op    = OP_LDAY;
        state_nxt = S_Y400;
        k_nxt     = 5'd4;
      end
      S_Y400: begin
        cmd.op = OP_Y400;
        if (last_k) begin
          state_nxt = S_Y100;
          k_nxt     = 5'd1;
        end
      end
      S_Y100: begin
        cmd.op = OP_Y100;
        if (last_k) begin
          state_nxt = S_Y4;
          k_nxt     = 5'd4;
        end
      end
      S_Y4: begin
        cmd.op = OP_Y4;
        if (last_k) begin
          state_nxt = S_Y1;
          k_nxt     = 5'd1;
        end
      end
      S_Y1: begin
        cmd.op = OP_Y1;
        if (last_k) begin
          state_nxt = S_YD;
        end
      end
      S_YD: begin
        cmd.op    = OP_YD;
        state_nxt = S_MON;
      end
      S_MON: begin
        cmd.op = OP_MON;
        if (sts.mon_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (cmd.load_out) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      k_r       <= 5'd0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      k_r       <= k_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;

  // a waiting result is never dropped or overwritten
  `AST_NEXT(a_out_hold, out_vld_r && !out_tready, out_vld_r)
  `AST_IMPLY(a_no_overwrite, cmd.load_out, !out_vld_r || out_tready)
  `AST_NEXT(a_accept_path, in_tvalid && state_r == S_IDLE, state_r == S_DAY || state_r == S_FIN)
  `AST_IMPLY(a_day_count, state_r == S_DAY, k_r <= 5'(DAY_W - 1))

endmodule

// ===== rtl/epoch_seconds_to_calendar_unit.sv =====
// ---------------------------------------------------------------------------
// epoch_seconds_to_calendar_unit
// signed epoch seconds to gregorian date, day of year, weekday and time of day
// ---------------------------------------------------------------------------
// one conversion at a time: a transfer is taken only while the sequencer is
// idle, and the time to out_tvalid varies with the month walk. the shared
// compare and subtract unit works through 22 day bits, 5 hour bits, 6 minute
// bits and the 400/100/4/1 year strides; the month walk that follows takes
// one month per cycle. a finished result waits in the output register, so
// the next input is taken while it is still unread, and a result that is
// still unread when the next one is done holds the sequencer until it is
// taken.
// inputs outside years 1 to 9999 return the out-of-range flag with zero data.
// ---------------------------------------------------------------------------
module epoch_seconds_to_calendar_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [38:0] epoch_seconds, signed
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // year, month, mday, yday, wday,
                                  // hour, minute, second from bit 0 up
  output logic        out_tuser   // out_of_range
);
  import es2cal_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic [DATA_W-1:0] out_data;

  es2cal_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  es2cal_dp u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .in_data  (in_tdata[IN_W-1:0]),
    .sts      (sts),
    .out_data (out_data),
    .out_oor  (out_tuser)
  );

  assign out_tdata = {4'd0, out_data};

endmodule
